// ----- rtl/mbtrs_pkg.sv -----
package mbtrs_pkg;

  // frame and response layout
  localparam int HDR_BYTES      = 12;
  localparam int READ_HDR_BYTES = 9;
  localparam int MAX_READ_WORDS = 2;
  localparam int REG_COUNT_DEF  = 2;

  localparam logic [7:0] FC_READ       = 8'h03;
  localparam logic [7:0] FC_WRITE      = 8'h06;
  localparam logic [7:0] UNIT_ID_RESET = 8'd1;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_REPLY
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic frame_byte;
    logic frame_close;
    logic local_wr;
    logic decode;
    logic emit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic hdr_done;
    logic fc_known;
    logic at_last;
  } sts_t;

endpackage

// ----- rtl/modbus_tcp_register_server_top.sv -----
// Modbus TCP holding register server.
// Input channel s_*: one item per request byte (s_tuser = 0) or per local
// register update (s_tuser = 1); s_tlast marks the final byte of a frame.
// The first 12 bytes of a frame are kept, later ones ignored.
// Output channel m_*: the response bytes, m_tlast on the final one.
// A read (function 0x03) answers with 9 to 13 bytes, a single write (0x06)
// echoes the 12 header bytes; short frames and other codes give no reply.
// Request bytes and local updates are taken one per cycle while idle. After
// the final byte of a full frame the block decodes the request in its decode
// state, then sends one response byte per cycle from its output register
// while m_tready allows; the input channel is held off during decode and
// response.
// A stalled last response byte does not block the next frame's input.
// cfg_wen/cfg_wdata write the unit id for read responses.
// Reset clears the register table and the header count and sets unit id 1.
module modbus_tcp_register_server_top
  import mbtrs_pkg::*;
#(
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // frame_byte[7:0], local_index[8], local_value[24:9]
  input  logic        s_tuser,  // req_type
  input  logic        s_tlast,  // frame_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // reply_byte[7:0]
  output logic        m_tlast   // reply_last
);

  cmd_t cmd;
  sts_t sts;

  mbtrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  mbtrs_dp #(
    .REG_COUNT (REG_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_byte    (s_tdata[7:0]),
    .in_index   (s_tdata[8]),
    .in_value   (s_tdata[24:9]),
    .cmd        (cmd),
    .sts        (sts),
    .reply_byte (m_tdata),
    .reply_last (m_tlast)
  );

endmodule

// ----- rtl/mbtrs_ctrl.sv -----
module mbtrs_ctrl
  import mbtrs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tuser,
  input  logic s_tlast,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state;
  state_t state_next;
  logic   m_tvalid_next;
  logic   accept;
  logic   out_free;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && !s_tuser && s_tlast && sts.hdr_done) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = sts.fc_known ? S_REPLY : S_IDLE;
      end
      S_REPLY: begin
        if (out_free && sts.at_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready        = 1'b0;
    cmd             = '0;
    unique case (state)
      S_IDLE: begin
        s_tready        = 1'b1;
        cmd.frame_byte  = s_tvalid && !s_tuser;
        cmd.frame_close = s_tvalid && !s_tuser && s_tlast;
        cmd.local_wr    = s_tvalid && s_tuser;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
      end
      S_REPLY: begin
        cmd.emit = out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd.emit) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // decode lasts exactly one cycle
  a_decode_once: assert property (@(posedge clk) disable iff (rst)
    state == S_DECODE |=> state != S_DECODE)
    else $error("decode state held");

  // the final reply item returns the controller to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && sts.at_last |=> state == S_IDLE)
    else $error("reply did not end after last item");

  // an emitted item is presented on the next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_tvalid)
    else $error("emitted item not valid");

endmodule

// ----- rtl/mbtrs_dp.sv -----
module mbtrs_dp
  import mbtrs_pkg::*;
#(
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata,
  input  logic [7:0]  in_byte,
  input  logic        in_index,
  input  logic [15:0] in_value,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic [7:0]  reply_byte,
  output logic        reply_last
);

  localparam int          IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [16:0] RC17  = 17'(REG_COUNT);
  localparam logic [3:0]  HDR_N = 4'(HDR_BYTES);

  logic [7:0]       frame_store [HDR_BYTES];
  logic [3:0]       bytes_seen;
  logic [15:0]      holding_table [REG_COUNT];
  logic [7:0]       unit_id;
  logic             is_read;
  logic [1:0]       n_words;
  logic [IDX_W-1:0] base;
  logic [3:0]       last_idx;
  logic [3:0]       k;

  logic [7:0]       fc;
  logic [15:0]      addr;
  logic [15:0]      cnt;
  logic             addr_ok;
  logic [16:0]      sum;
  logic [15:0]      avail;
  logic [15:0]      eff;
  logic [1:0]       words;
  logic [IDX_W:0]   rd_idx;
  logic [15:0]      rd_word;
  logic [7:0]       bc;
  logic [7:0]       byte_mux;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_id <= UNIT_ID_RESET;
    end else if (cfg_wen) begin
      unit_id <= cfg_wdata;
    end
  end

  // header collection
  always_ff @(posedge clk) begin
    if (cmd.frame_byte && bytes_seen < HDR_N) begin
      frame_store[bytes_seen] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
    end else if (cmd.frame_close) begin
      bytes_seen <= '0;
    end else if (cmd.frame_byte && bytes_seen < HDR_N) begin
      bytes_seen <= bytes_seen + 4'd1;
    end
  end

  // request decode and read range clamp
  always_comb begin
    fc      = frame_store[7];
    addr    = {frame_store[8], frame_store[9]};
    cnt     = {frame_store[10], frame_store[11]};
    addr_ok = {1'b0, addr} < RC17;
    sum     = {1'b0, addr} + {1'b0, cnt};
    avail   = 16'(RC17 - {1'b0, addr});
    eff     = (sum > RC17) ? avail : cnt;
    if (!addr_ok) begin
      words = 2'd0;
    end else if (eff >= 16'(MAX_READ_WORDS)) begin
      words = 2'(MAX_READ_WORDS);
    end else begin
      words = eff[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      is_read  <= (fc == FC_READ);
      n_words  <= words;
      base     <= addr[IDX_W-1:0];
      last_idx <= (fc == FC_READ) ? 4'(READ_HDR_BYTES - 1) + {1'b0, words, 1'b0}
                                  : HDR_N - 4'd1;
    end
  end

  // holding register table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        holding_table[i] <= '0;
      end
    end else if (cmd.decode) begin
      if (fc == FC_WRITE && addr_ok) holding_table[addr[IDX_W-1:0]] <= cnt;
    end else if (cmd.local_wr) begin
      if (int'(in_index) < REG_COUNT) holding_table[IDX_W'(in_index)] <= in_value;
    end
  end

  // table read for the word being sent
  always_comb begin
    rd_idx  = {1'b0, base} + {{IDX_W{1'b0}}, k >= 4'(READ_HDR_BYTES + 2)};
    rd_word = (int'(rd_idx) < REG_COUNT) ? holding_table[rd_idx[IDX_W-1:0]] : 16'd0;
    bc      = {5'd0, n_words, 1'b0};
  end

  // response byte select
  always_comb begin
    byte_mux = 8'd0;
    if (is_read) begin
      case (k) inside
        4'd0:             byte_mux = frame_store[0];
        4'd1:             byte_mux = frame_store[1];
        4'd2, 4'd3, 4'd4: byte_mux = 8'd0;
        4'd5:             byte_mux = 8'd3 + bc;
        4'd6:             byte_mux = unit_id;
        4'd7:             byte_mux = FC_READ;
        4'd8:             byte_mux = bc;
        default:          byte_mux = k[0] ? rd_word[15:8] : rd_word[7:0];
      endcase
    end else if (k < HDR_N) begin
      byte_mux = frame_store[k];
    end
  end

  // output register and reply position
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      reply_byte <= byte_mux;
      reply_last <= (k == last_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.decode) begin
      k <= '0;
    end else if (cmd.emit) begin
      k <= k + 4'd1;
    end
  end

  // status to controller
  assign sts.hdr_done = bytes_seen >= HDR_N - 4'd1;
  assign sts.fc_known = (fc == FC_READ) || (fc == FC_WRITE);
  assign sts.at_last  = (k == last_idx);

  // header count never runs past the store
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= HDR_N)
    else $error("header count overflow");

  // no item is sent past the end of the response
  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> k <= last_idx)
    else $error("reply position past last item");

  // every reply starts at its first byte
  a_decode_rewind: assert property (@(posedge clk) disable iff (rst)
    cmd.decode |=> k == 4'd0)
    else $error("reply position not rewound");

endmodule
